// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files; shtv_core includes them.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that cons holds whenever ante holds, outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/shtv_pkg.sv =====
`default_nettype none

package shtv_pkg;

   // line buffer size; a chunk closes after LINE_BUFFER-1 bytes
   localparam int LINE_BUFFER = 256;
   localparam int LEN_W       = $clog2(LINE_BUFFER);
   localparam logic [LEN_W-1:0] CHUNK_MAX = LEN_W'(LINE_BUFFER - 1);

   localparam int LIMIT_W = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd40;

   // offset of the field separator after the hex code
   localparam logic [3:0] HEX_DIGITS = 4'd8;
   localparam logic [3:0] LEAD_MAX   = 4'd9;

   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NL       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   // register byte addresses (paddr bit 2 selects the register slot)
   localparam int ADDR_W = 3;
   localparam logic [ADDR_W-1:0] ADDR_LINE_LIMIT = 3'd0;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SECTION   = 2'd1,
      STATUS_CODE_LINE = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [3:0]       lead_offset;
      logic             in_leading_blank;
      logic             hex_good;
      logic             ninth_is_space;
      logic             tail_after_ninth;
      logic             starts_bracket;
      logic             close_bracket_seen;
      logic             has_content;
   } chunk_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] chunks_done;
      logic               section_found;
      status_type         verdict;
      logic               halted;
      logic               any_byte;
   } file_type;

   typedef struct packed {
      status_type         status;
      logic [LIMIT_W-1:0] lines_examined;
   } result_type;

   localparam chunk_type CHUNK_RESET = '{
      length: '0, lead_offset: '0, in_leading_blank: 1'b1, hex_good: 1'b1,
      ninth_is_space: 1'b0, tail_after_ninth: 1'b0, starts_bracket: 1'b0,
      close_bracket_seen: 1'b0, has_content: 1'b0};

   localparam file_type FILE_RESET = '{
      chunks_done: '0, section_found: 1'b0, verdict: STATUS_OK,
      halted: 1'b0, any_byte: 1'b0};

   function automatic logic is_hex_digit(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_trimmed(input logic [7:0] c);
      return (c == CHAR_NL) || (c == CHAR_CR) || (c == CHAR_SPACE);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/shtv_csr.sv =====
`default_nettype none

module shtv_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [shtv_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready,
   output logic      [shtv_pkg::LIMIT_W-1:0]  line_limit
);

   logic [shtv_pkg::LIMIT_W-1:0] limit_ff;
   logic [shtv_pkg::LIMIT_W-1:0] limit_in;
   logic                         hit;

   assign hit = (paddr[2] == shtv_pkg::ADDR_LINE_LIMIT[2]);

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && hit) begin
         limit_in = pwdata[shtv_pkg::LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= shtv_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign pready     = 1'b1;
   assign prdata     = hit ? {{(32 - shtv_pkg::LIMIT_W){1'b0}}, limit_ff} : 32'd0;
   assign line_limit = limit_ff;

endmodule

`default_nettype wire

// ===== hdl/shtv_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module shtv_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [7:0]                    ch,
   input  wire logic                          has_char,
   input  wire logic                          end_of_file,
   input  wire logic [shtv_pkg::LIMIT_W-1:0]  line_limit,
   output logic                               result_valid,
   output shtv_pkg::result_type               result
);

   shtv_pkg::chunk_type chunk_ff, chunk_in, upd;
   shtv_pkg::file_type  file_ff, file_in;
   logic                take;
   logic                byte_close;
   logic                close_req;
   logic [shtv_pkg::LIMIT_W-1:0] done_inc;

   assign take     = has_char && !file_ff.halted;
   assign done_inc = file_ff.chunks_done + 1'b1;

   always_comb begin
      upd        = chunk_ff;
      file_in    = file_ff;
      byte_close = 1'b0;
      result     = '{status: shtv_pkg::STATUS_OK, lines_examined: '0};

      if (take) begin
         if (chunk_ff.length == '0) begin
            upd.starts_bracket = (ch == shtv_pkg::CHAR_LBRACKET);
         end
         if (ch == shtv_pkg::CHAR_RBRACKET) begin
            upd.close_bracket_seen = 1'b1;
         end
         if (!shtv_pkg::is_trimmed(ch)) begin
            upd.has_content = 1'b1;
         end
         if (!(chunk_ff.in_leading_blank &&
               (ch == shtv_pkg::CHAR_SPACE || ch == shtv_pkg::CHAR_TAB))) begin
            upd.in_leading_blank = 1'b0;
            if (chunk_ff.lead_offset < shtv_pkg::HEX_DIGITS) begin
               if (!shtv_pkg::is_hex_digit(ch)) begin
                  upd.hex_good = 1'b0;
               end
            end else if (chunk_ff.lead_offset == shtv_pkg::HEX_DIGITS) begin
               upd.ninth_is_space = (ch == shtv_pkg::CHAR_SPACE);
            end else if (chunk_ff.ninth_is_space && !shtv_pkg::is_trimmed(ch)) begin
               upd.tail_after_ninth = 1'b1;
            end
            if (chunk_ff.lead_offset < shtv_pkg::LEAD_MAX) begin
               upd.lead_offset = chunk_ff.lead_offset + 1'b1;
            end
         end
         upd.length = chunk_ff.length + 1'b1;
         byte_close = (ch == shtv_pkg::CHAR_NL) || (upd.length >= shtv_pkg::CHUNK_MAX);
      end

      if (has_char) begin
         file_in.any_byte = 1'b1;
      end

      // at most one chunk closes per transaction: a byte close leaves length zero
      close_req = !file_ff.halted &&
                  (byte_close || (end_of_file && upd.length != '0));

      chunk_in = upd;
      if (close_req) begin
         chunk_in = shtv_pkg::CHUNK_RESET;
         if (file_ff.chunks_done >= line_limit) begin
            file_in.halted = 1'b1;
         end else begin
            file_in.chunks_done = done_inc;
            if (upd.has_content) begin
               if (upd.starts_bracket) begin
                  file_in.section_found = 1'b1;
                  if (!upd.close_bracket_seen) begin
                     file_in.verdict = shtv_pkg::STATUS_SECTION;
                     file_in.halted  = 1'b1;
                  end
               end else if (upd.ninth_is_space && upd.tail_after_ninth &&
                            !upd.hex_good) begin
                  file_in.verdict = shtv_pkg::STATUS_CODE_LINE;
                  file_in.halted  = 1'b1;
               end
            end
            if (done_inc >= line_limit) begin
               file_in.halted = 1'b1;
            end
         end
      end

      priority if (!file_in.any_byte) begin
         result.status = shtv_pkg::STATUS_EMPTY;
      end else if (!file_in.section_found && file_in.chunks_done != '0) begin
         result.status = shtv_pkg::STATUS_SECTION;
      end else begin
         result.status = file_in.verdict;
      end
      result.lines_examined = file_in.chunks_done;

      if (end_of_file) begin
         file_in  = shtv_pkg::FILE_RESET;
         chunk_in = shtv_pkg::CHUNK_RESET;
      end
   end

   assign result_valid = accept && end_of_file;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= shtv_pkg::CHUNK_RESET;
         file_ff  <= shtv_pkg::FILE_RESET;
      end else if (accept) begin
         chunk_ff <= chunk_in;
         file_ff  <= file_in;
      end
   end

   `ASSERT_IMPLY(a_halted_chunk_empty, clock, reset, file_ff.halted, chunk_ff.length == '0)
   `ASSERT_ALWAYS(a_lead_bound, clock, reset, chunk_ff.lead_offset <= shtv_pkg::LEAD_MAX)
   `ASSERT_ALWAYS(a_length_bound, clock, reset, chunk_ff.length < shtv_pkg::CHUNK_MAX)
   `ASSERT_IMPLY(a_blank_no_offset, clock, reset, chunk_ff.in_leading_blank, chunk_ff.lead_offset == '0)

endmodule

`default_nettype wire

// ===== hdl/shtv_out_reg.sv =====
`default_nettype none

module shtv_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire shtv_pkg::result_type  load_data,
   output logic                       free,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output shtv_pkg::result_type       out_data
);

   logic                 valid_ff, valid_in;
   shtv_pkg::result_type data_ff, data_in;

   // slot is free when empty or being drained this cycle
   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/sectioned_hex_text_validator_unit.sv =====
// A verdict is on rsp_valid in the cycle after the end-of-file transaction.
// One byte is taken per cycle while req_ready is high; the chunk and file state update on each accepted transaction.
// The result register holds one verdict; input stalls only while it is full and not taken.
// Reset (synchronous, active high): per-file state cleared, line_limit returns to 40,
// result register emptied. No clearing pass; the block accepts bytes right after reset.
`default_nettype none

module sectioned_hex_text_validator_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // byte stream
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_has_char,
   input  wire logic                          req_end_of_file,
   // verdict
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [1:0]                    rsp_status,
   output logic      [shtv_pkg::LIMIT_W-1:0]  rsp_lines_examined,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [shtv_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);

   logic                         accept;
   logic                         slot_free;
   logic                         result_valid;
   logic [shtv_pkg::LIMIT_W-1:0] line_limit;
   shtv_pkg::result_type         result;
   shtv_pkg::result_type         rsp_data;

   // Hold the line_limit register; writes complete in the access phase.
   shtv_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .line_limit (line_limit)
   );

   // Accept a byte whenever the result slot can take a verdict this cycle;
   // a byte without end of file never needs the slot but is gated the same
   // way to keep the handshake simple and ordered.
   assign req_ready = slot_free;
   assign accept    = req_valid && req_ready;

   // Advance the chunk and file state once per accepted transaction.
   shtv_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ch           (req_ch),
      .has_char     (req_has_char),
      .end_of_file  (req_end_of_file),
      .line_limit   (line_limit),
      .result_valid (result_valid),
      .result       (result)
   );

   // Hold the verdict until the consumer takes it.
   shtv_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .free      (slot_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_lines_examined = rsp_data.lines_examined;

endmodule

`default_nettype wire

// ===== dv/validator_checker.sv =====
`timescale 1ns / 1ps

module validator_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_has_char,
   input  wire logic                          req_end_of_file,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [1:0]                    rsp_status,
   input  wire logic [shtv_pkg::LIMIT_W-1:0]  rsp_lines_examined,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [shtv_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   input  wire logic [31:0]                   prdata,
   input  wire logic                          pready,
   output int                                 mismatch_count,
   output int                                 verdicts_owed
);

   // current line chunk
   logic [7:0]         ln_len;
   logic [3:0]         ln_lead;
   bit                 ln_blank;
   bit                 ln_hex_ok;
   bit                 ln_sep;
   bit                 ln_tail;
   bit                 ln_hdr;
   bit                 ln_close;
   bit                 ln_text;

   // current file
   logic [shtv_pkg::LIMIT_W-1:0] f_count;
   bit                           f_section;
   shtv_pkg::status_type         f_fault;
   bit                           f_stop;
   bit                           f_any;

   logic [shtv_pkg::LIMIT_W-1:0] lim_q;
   shtv_pkg::result_type         verdict_q[$];

   function automatic bit hex_char(input logic [7:0] c);
      logic [7:0] lc;
      lc = c | 8'h20;
      return (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
   endfunction

   function automatic bit spacing_char(input logic [7:0] c);
      return c == shtv_pkg::CHAR_NL || c == shtv_pkg::CHAR_CR || c == shtv_pkg::CHAR_SPACE;
   endfunction

   task automatic wipe_line();
      ln_len    = '0;
      ln_lead   = '0;
      ln_blank  = 1'b1;
      ln_hex_ok = 1'b1;
      ln_sep    = 1'b0;
      ln_tail   = 1'b0;
      ln_hdr    = 1'b0;
      ln_close  = 1'b0;
      ln_text   = 1'b0;
   endtask

   task automatic wipe_file();
      wipe_line();
      f_count   = '0;
      f_section = 1'b0;
      f_fault   = shtv_pkg::STATUS_OK;
      f_stop    = 1'b0;
      f_any     = 1'b0;
   endtask

   task automatic close_line();
      if (f_count >= lim_q) begin
         f_stop = 1'b1;
      end else begin
         f_count++;
         if (ln_text) begin
            if (ln_hdr) begin
               f_section = 1'b1;
               if (!ln_close) begin
                  f_fault = shtv_pkg::STATUS_SECTION;
                  f_stop  = 1'b1;
               end
            end else if (ln_sep && ln_tail && !ln_hex_ok) begin
               f_fault = shtv_pkg::STATUS_CODE_LINE;
               f_stop  = 1'b1;
            end
         end
         if (f_count >= lim_q) f_stop = 1'b1;
      end
      wipe_line();
   endtask

   task automatic take_char(input logic [7:0] c);
      if (ln_len == 0) ln_hdr = (c == shtv_pkg::CHAR_LBRACKET);
      if (c == shtv_pkg::CHAR_RBRACKET) ln_close = 1'b1;
      if (!spacing_char(c)) ln_text = 1'b1;
      if (!(ln_blank && (c == shtv_pkg::CHAR_SPACE || c == shtv_pkg::CHAR_TAB))) begin
         ln_blank = 1'b0;
         if (ln_lead < shtv_pkg::HEX_DIGITS) begin
            if (!hex_char(c)) ln_hex_ok = 1'b0;
         end else if (ln_lead == shtv_pkg::HEX_DIGITS) begin
            ln_sep = (c == shtv_pkg::CHAR_SPACE);
         end else if (ln_sep && !spacing_char(c)) begin
            ln_tail = 1'b1;
         end
         if (ln_lead < shtv_pkg::LEAD_MAX) ln_lead++;
      end
      ln_len++;
      if (c == shtv_pkg::CHAR_NL || ln_len >= shtv_pkg::CHUNK_MAX) close_line();
   endtask

   task automatic predict_item(input logic [7:0] c, input logic has, input logic last);
      shtv_pkg::result_type r;
      if (has) begin
         f_any = 1'b1;
         if (!f_stop) take_char(c);
      end
      if (last) begin
         if (!f_stop && ln_len != 0) close_line();
         if (!f_any) r.status = shtv_pkg::STATUS_EMPTY;
         else if (!f_section && f_count != 0) r.status = shtv_pkg::STATUS_SECTION;
         else r.status = f_fault;
         r.lines_examined = f_count;
         verdict_q.push_back(r);
         wipe_file();
      end
   endtask

   task automatic note_fault(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t checker: %s expected %0d got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      shtv_pkg::result_type want;
      if (reset) begin
         lim_q = shtv_pkg::LIMIT_RESET;
         wipe_file();
         verdict_q.delete();
         mismatch_count = 0;
      end else begin
         if (psel && penable && !pwrite && pready && paddr == shtv_pkg::ADDR_LINE_LIMIT &&
             prdata[shtv_pkg::LIMIT_W-1:0] != lim_q)
            note_fault("line_limit readback", lim_q, prdata[shtv_pkg::LIMIT_W-1:0]);
         if (psel && penable && pwrite && pready && paddr == shtv_pkg::ADDR_LINE_LIMIT)
            lim_q = pwdata[shtv_pkg::LIMIT_W-1:0];
         if (req_valid && req_ready)
            predict_item(req_ch, req_has_char, req_end_of_file);
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               note_fault("verdict with none owed, status", -1, rsp_status);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_status != want.status)
                  note_fault("status", want.status, rsp_status);
               if (rsp_lines_examined != want.lines_examined)
                  note_fault("lines_examined", want.lines_examined, rsp_lines_examined);
            end
         end
      end
      verdicts_owed = verdict_q.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int PERIOD       = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 860;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [7:0]                    req_ch;
   logic                          req_has_char;
   logic                          req_end_of_file;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [1:0]                    rsp_status;
   logic [shtv_pkg::LIMIT_W-1:0]  rsp_lines_examined;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [shtv_pkg::ADDR_W-1:0]   paddr;
   logic [31:0]                   pwdata;
   logic [31:0]                   prdata;
   logic                          pready;

   int                  mismatch_count;
   int                  verdicts_owed;
   int                  cycle_count = 0;
   int                  items_sent  = 0;
   int                  files_sent  = 0;
   int                  gap_den     = 0;   // 1-in-N chance of an input gap; 0 means none
   int                  stall_den   = 0;   // same for result back-pressure
   bit                  calm        = 1'b0; // closing stretch: no idling on either side
   logic [7:0]          text_q[$];          // bytes of the file being built

   always #(PERIOD / 2) clock = ~clock;

   sectioned_hex_text_validator_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ch             (req_ch),
      .req_has_char       (req_has_char),
      .req_end_of_file    (req_end_of_file),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_lines_examined (rsp_lines_examined),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   validator_checker i_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ch             (req_ch),
      .req_has_char       (req_has_char),
      .req_end_of_file    (req_end_of_file),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_lines_examined (rsp_lines_examined),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .mismatch_count     (mismatch_count),
      .verdicts_owed      (verdicts_owed)
   );

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Result back-pressure: now and then drop ready for a burst, hold it high otherwise.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && stall_den != 0 && $urandom_range(1, stall_den) == 1) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // Present one transaction at the falling edge, hold it until the rising edge that
   // accepts it. An optional idle burst goes in front of it.
   task automatic send_item(input logic [7:0] c, input logic has, input logic last);
      @(negedge clock);
      if (!calm && gap_den != 0 && $urandom_range(1, gap_den) == 1) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_ch          = c;
      req_has_char    = has;
      req_end_of_file = last;
      do @(posedge clock); while (!req_ready);
      if (has || last) items_sent++;
   endtask

   // Stream the built file. The end either rides on the last byte or follows as a bare
   // end marker; a stray bare step (no byte, no end) is slipped in now and then.
   task automatic send_file(input bit bare_end);
      int n;
      n = text_q.size();
      if (n == 0) bare_end = 1'b1;
      foreach (text_q[i]) begin
         if ($urandom_range(0, 29) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(text_q[i], 1'b1, !bare_end && i == n - 1);
      end
      if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
      files_sent++;
      text_q.delete();
   endtask

   // Drop valid and wait for the block to drain before touching the register.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (verdicts_owed != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Write line_limit (junk in the unused upper bits), then read it back.
   task automatic write_limit(input logic [shtv_pkg::LIMIT_W-1:0] v);
      settle();
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = shtv_pkg::ADDR_LINE_LIMIT;
      pwdata  = ($urandom & 32'hFFFF_FC00) | 32'(v);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] any_hex();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   function automatic logic [7:0] non_hex();
      string odd;
      odd = "gGzZ:/@h.x";
      return odd[$urandom_range(0, 9)];
   endfunction

   function automatic logic [7:0] any_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   task automatic put_header(input bit closed);
      text_q.push_back(shtv_pkg::CHAR_LBRACKET);
      repeat ($urandom_range(0, 4)) text_q.push_back(any_letter());
      if (closed) text_q.push_back(shtv_pkg::CHAR_RBRACKET);
      text_q.push_back(shtv_pkg::CHAR_NL);
   endtask

   // Code line: optional indent, eight hex digits (one spoilt if not clean),
   // a separator that is usually a space, and a tail that may be empty.
   task automatic put_code(input bit clean);
      int bad;
      repeat ($urandom_range(0, 2))
         text_q.push_back($urandom_range(0, 1) ? shtv_pkg::CHAR_SPACE : shtv_pkg::CHAR_TAB);
      bad = clean ? -1 : $urandom_range(0, 7);
      for (int i = 0; i < 8; i++) text_q.push_back(i == bad ? non_hex() : any_hex());
      text_q.push_back($urandom_range(0, 7) == 0 ? any_letter() : shtv_pkg::CHAR_SPACE);
      repeat ($urandom_range(0, 4)) text_q.push_back(any_letter());
      if ($urandom_range(0, 5) == 0) text_q.push_back(shtv_pkg::CHAR_SPACE);
      if ($urandom_range(0, 5) == 0) text_q.push_back(shtv_pkg::CHAR_CR);
      text_q.push_back(shtv_pkg::CHAR_NL);
   endtask

   task automatic put_blank();
      repeat ($urandom_range(0, 3))
         text_q.push_back($urandom_range(0, 1) ? shtv_pkg::CHAR_SPACE : shtv_pkg::CHAR_CR);
      text_q.push_back(shtv_pkg::CHAR_NL);
   endtask

   task automatic put_noise();
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 0) text_q.push_back(shtv_pkg::CHAR_NL);
   endtask

   // Mostly well-formed files with random content; a few empty or pure noise.
   task automatic make_file();
      int kind;
      kind = $urandom_range(0, 19);
      if (kind == 0) return;
      if (kind <= 2) begin
         repeat ($urandom_range(1, 3)) put_noise();
      end else begin
         if ($urandom_range(0, 3) == 0) put_blank();
         if ($urandom_range(0, 9) != 0) put_header($urandom_range(0, 9) != 0);
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 9))
               0:       put_blank();
               1:       put_header($urandom_range(0, 5) != 0);
               2:       put_noise();
               default: put_code($urandom_range(0, 5) != 0);
            endcase
         end
      end
      // leave the last chunk open so the end marker closes it
      if ($urandom_range(0, 3) == 0 && text_q.size() != 0 && text_q[$] == shtv_pkg::CHAR_NL)
         void'(text_q.pop_back());
   endtask

   function automatic logic [shtv_pkg::LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0:       return 10'd1;
         1:       return 10'd1023;
         2:       return shtv_pkg::LIMIT_RESET;
         default: return 10'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic int pick_den();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 2;
         2:       return 6;
         default: return 15;
      endcase
   endfunction

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_ch          = '0;
      req_has_char    = 1'b0;
      req_end_of_file = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = shtv_pkg::ADDR_LINE_LIMIT;
      pwdata          = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed files, line_limit at its reset value first.
      send_file(1'b1);                         // empty file
      send_item(8'hA5, 1'b0, 1'b0);            // bare step: ignore
      put_str("[");                            // unclosed header ending on the last byte
      send_file(1'b0);
      put_str("[s]\n0123abCD x\n");            // good section and code line
      send_file(1'b1);
      put_str("[]\n \t0000000g y");            // indented bad hex, chunk cut by the end
      send_file(1'b0);
      // blank then NUL, no section
      text_q = {shtv_pkg::CHAR_CR, shtv_pkg::CHAR_SPACE, shtv_pkg::CHAR_NL, 8'h00,
                shtv_pkg::CHAR_NL};
      send_file(1'b0);
      write_limit(10'd0);                      // nothing examined
      put_str("z\n");
      send_file(1'b0);
      write_limit(10'd1023);
      // change the limit part way through a file
      put_str("[k]\n");
      foreach (text_q[i]) send_item(text_q[i], 1'b1, 1'b0);
      text_q.delete();
      write_limit(10'd1);
      put_str("FFFFFFFF q\n");
      send_file(1'b1);

      // Random phases: new limit and idling pattern every eight files.
      items_sent = 0;
      files_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (files_sent % 8 == 0) begin
            write_limit(pick_limit());
            gap_den   = pick_den();
            stall_den = pick_den();
         end
         make_file();
         if (files_sent == 5) begin
            // one full-buffer chunk: a header that closes exactly at the buffer end
            text_q.push_back(shtv_pkg::CHAR_LBRACKET);
            repeat (253) text_q.push_back(any_letter());
            text_q.push_back(shtv_pkg::CHAR_RBRACKET);
            put_str("ab\n");
         end
         send_file($urandom_range(0, 3) == 0);
      end

      // Closing stretch at full rate.
      write_limit(shtv_pkg::LIMIT_RESET);
      calm = 1'b1;
      repeat (6) begin
         make_file();
         send_file($urandom_range(0, 3) == 0);
      end

      // Drain, then allow the block's latency before the verdict.
      @(negedge clock);
      req_valid = 1'b0;
      while (verdicts_owed != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && verdicts_owed == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
